// File: sv/depth_pixel_backprojection_macros.svh
// assertion helpers for the checker file dpb_checker
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define DPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dpb_pkg.sv
package dpb_pkg;

  // register file
  typedef enum logic [2:0] {
    CFG_FOCAL_X      = 3'd0,
    CFG_FOCAL_Y      = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_MIN_DEPTH    = 3'd4,
    CFG_MAX_DEPTH    = 3'd5,
    CFG_PIXEL_STRIDE = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] FocalXRst   = 16'd8000;
  localparam logic [15:0] FocalYRst   = 16'd8000;
  localparam logic [15:0] CenterXRst  = 16'd5120;
  localparam logic [15:0] CenterYRst  = 16'd3840;
  localparam logic [15:0] MinDepthRst = 16'd100;
  localparam logic [15:0] MaxDepthRst = 16'd50000;
  localparam logic [3:0]  StrideRst   = 4'd3;

  // reciprocal of the stride, ceil(2^16 / d), exact floor division for 12-bit indices
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = 17;
  localparam logic [RecipW-1:0] StrideRecip [16] = '{
    17'd65536,
    17'((65536 + 1 - 1) / 1),
    17'((65536 + 2 - 1) / 2),
    17'((65536 + 3 - 1) / 3),
    17'((65536 + 4 - 1) / 4),
    17'((65536 + 5 - 1) / 5),
    17'((65536 + 6 - 1) / 6),
    17'((65536 + 7 - 1) / 7),
    17'((65536 + 8 - 1) / 8),
    17'((65536 + 9 - 1) / 9),
    17'((65536 + 10 - 1) / 10),
    17'((65536 + 11 - 1) / 11),
    17'((65536 + 12 - 1) / 12),
    17'((65536 + 13 - 1) / 13),
    17'((65536 + 14 - 1) / 14),
    17'((65536 + 15 - 1) / 15)
  };

  // divider geometry: quotient bits below the saturation point, one per stage
  localparam int unsigned ProdW     = 32;
  localparam int unsigned QuotW     = 23;
  localparam int unsigned DivStages = QuotW;
  localparam int unsigned RemW      = 16;
  localparam int unsigned CoordW    = 24;

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [15:0] depth_value;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [15:0]        point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
  } point_t;

  // fields that ride alongside the arithmetic unchanged
  typedef struct packed {
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } side_t;

endpackage

// File: sv/depth_pixel_backprojection.sv
// channel   direction  handshake                        payload
// pixel     in         pixel_valid_i / pixel_stall_o    pixel_i (dpb_pkg::pixel_t)
// point     out        point_valid_o / point_stall_i    point_o (dpb_pkg::point_t)
// config    in         cfg_we_i, no back-pressure       cfg_idx_i, cfg_wdata_i
//
// one pixel per cycle sustained while no blocked point stalls the pipe (pixel_stall_o)
// stages: index/offset stage, multiply stage, 24 divider stages, output register
// the two restoring dividers (one quotient bit per stage) set the pipeline depth
// rst_ni clears valid bits and loads the register defaults; no clearing pass
// point_stall_i freezes the pipe only while the tail stage holds a point,
// so rejected pixels (bubbles) are squeezed out at the tail during a stall
module depth_pixel_backprojection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // pixel requests
  input  logic                          pixel_valid_i,
  input  dpb_pkg::pixel_t               pixel_i,
  output logic                          pixel_stall_o,
  // point requests
  output logic                          point_valid_o,
  output dpb_pkg::point_t               point_o,
  input  logic                          point_stall_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0] min_depth_q, max_depth_q;
  logic [3:0]  stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= dpb_pkg::FocalXRst;
      focal_y_q   <= dpb_pkg::FocalYRst;
      center_x_q  <= dpb_pkg::CenterXRst;
      center_y_q  <= dpb_pkg::CenterYRst;
      min_depth_q <= dpb_pkg::MinDepthRst;
      max_depth_q <= dpb_pkg::MaxDepthRst;
      stride_q    <= dpb_pkg::StrideRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpb_pkg::CFG_FOCAL_X:      focal_x_q   <= cfg_wdata_i;
        dpb_pkg::CFG_FOCAL_Y:      focal_y_q   <= cfg_wdata_i;
        dpb_pkg::CFG_CENTER_X:     center_x_q  <= cfg_wdata_i;
        dpb_pkg::CFG_CENTER_Y:     center_y_q  <= cfg_wdata_i;
        dpb_pkg::CFG_MIN_DEPTH:    min_depth_q <= cfg_wdata_i;
        dpb_pkg::CFG_MAX_DEPTH:    max_depth_q <= cfg_wdata_i;
        dpb_pkg::CFG_PIXEL_STRIDE: stride_q    <= cfg_wdata_i[3:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control
  // ---------------------------------------------------------------------------
  logic advance;
  logic tail_valid;
  logic s1_valid_q, s2_valid_q;
  logic div_valid_q [dpb_pkg::DivStages+1];
  logic point_valid_q;

  assign tail_valid    = div_valid_q[dpb_pkg::DivStages];
  // the whole pipe shifts unless a finished point is blocked behind a held output
  assign advance       = !(point_valid_q && point_stall_i && tail_valid);
  assign pixel_stall_o = !advance;

  // ---------------------------------------------------------------------------
  // stage 1: stride quotient estimate, signed offsets, depth window
  // ---------------------------------------------------------------------------
  logic [3:0]                     step_eff;
  logic [dpb_pkg::RecipW-1:0]     recip;
  logic [dpb_pkg::RecipW+11:0]    row_scaled, col_scaled;
  logic [15:0]                    pos_x, pos_y;
  logic                           neg_x, neg_y;

  logic [11:0] s1_row_q, s1_col_q, s1_qrow_q, s1_qcol_q;
  logic [3:0]  s1_step_q;
  logic [15:0] s1_mag_x_q, s1_mag_y_q;
  logic        s1_neg_x_q, s1_neg_y_q, s1_depth_ok_q;
  dpb_pkg::side_t s1_side_q;

  assign step_eff   = (stride_q == 4'd0) ? 4'd1 : stride_q;
  assign recip      = dpb_pkg::StrideRecip[step_eff];
  assign row_scaled = (dpb_pkg::RecipW+12)'(pixel_i.pixel_row) * (dpb_pkg::RecipW+12)'(recip);
  assign col_scaled = (dpb_pkg::RecipW+12)'(pixel_i.pixel_col) * (dpb_pkg::RecipW+12)'(recip);
  // Q12.4 pixel position
  assign pos_x      = {pixel_i.pixel_col, 4'b0000};
  assign pos_y      = {pixel_i.pixel_row, 4'b0000};
  assign neg_x      = pos_x < center_x_q;
  assign neg_y      = pos_y < center_y_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_row_q       <= pixel_i.pixel_row;
      s1_col_q       <= pixel_i.pixel_col;
      s1_qrow_q      <= row_scaled[dpb_pkg::RecipShift +: 12];
      s1_qcol_q      <= col_scaled[dpb_pkg::RecipShift +: 12];
      s1_step_q      <= step_eff;
      s1_mag_x_q     <= neg_x ? (center_x_q - pos_x) : (pos_x - center_x_q);
      s1_mag_y_q     <= neg_y ? (center_y_q - pos_y) : (pos_y - center_y_q);
      s1_neg_x_q     <= neg_x;
      s1_neg_y_q     <= neg_y;
      s1_depth_ok_q  <= (pixel_i.depth_value >= min_depth_q) &&
                        (pixel_i.depth_value <= max_depth_q);
      s1_side_q      <= '{depth: pixel_i.depth_value, blue: pixel_i.blue_in,
                          green: pixel_i.green_in, red: pixel_i.red_in};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: stride check (quotient times step) and offset times depth
  // ---------------------------------------------------------------------------
  logic [15:0] row_back, col_back;
  logic        keep;

  logic [dpb_pkg::ProdW-1:0] s2_prod_x_q, s2_prod_y_q;
  logic                      s2_neg_x_q, s2_neg_y_q;
  dpb_pkg::side_t            s2_side_q;

  assign row_back = 16'(s1_qrow_q) * 16'(s1_step_q);
  assign col_back = 16'(s1_qcol_q) * 16'(s1_step_q);
  assign keep     = s1_depth_ok_q && (row_back == 16'(s1_row_q)) &&
                    (col_back == 16'(s1_col_q));

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_prod_x_q <= dpb_pkg::ProdW'(s1_mag_x_q) * dpb_pkg::ProdW'(s1_side_q.depth);
      s2_prod_y_q <= dpb_pkg::ProdW'(s1_mag_y_q) * dpb_pkg::ProdW'(s1_side_q.depth);
      s2_neg_x_q  <= s1_neg_x_q;
      s2_neg_y_q  <= s1_neg_y_q;
      s2_side_q   <= s1_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // divider stages: quotient by the focal length, saturated to 24 bits
  // ---------------------------------------------------------------------------
  logic signed [dpb_pkg::CoordW-1:0] coord_x, coord_y;
  dpb_pkg::side_t side_q [dpb_pkg::DivStages+1];

  dpb_divider u_div_x (
    .clk_i   (clk_i),
    .en_i    (advance),
    .prod_i  (s2_prod_x_q),
    .neg_i   (s2_neg_x_q),
    .focal_i (focal_x_q),
    .coord_o (coord_x)
  );

  dpb_divider u_div_y (
    .clk_i   (clk_i),
    .en_i    (advance),
    .prod_i  (s2_prod_y_q),
    .neg_i   (s2_neg_y_q),
    .focal_i (focal_y_q),
    .coord_o (coord_y)
  );

  // depth and colour ride alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_q[0] <= s2_side_q;
      for (int k = 1; k <= dpb_pkg::DivStages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits; rejected pixels drop out at stage 2
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int k = 0; k <= dpb_pkg::DivStages; k++) begin
        div_valid_q[k] <= 1'b0;
      end
    end else if (advance) begin
      s1_valid_q     <= pixel_valid_i;
      s2_valid_q     <= s1_valid_q && keep;
      div_valid_q[0] <= s2_valid_q;
      for (int k = 1; k <= dpb_pkg::DivStages; k++) begin
        div_valid_q[k] <= div_valid_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic           out_load;
  dpb_pkg::point_t point_q;

  assign out_load = !point_valid_q || !point_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_valid_q <= 1'b0;
    end else if (out_load) begin
      point_valid_q <= tail_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && tail_valid) begin
      point_q <= '{point_x:   coord_x,
                   point_y:   coord_y,
                   point_z:   side_q[dpb_pkg::DivStages].depth,
                   blue_out:  side_q[dpb_pkg::DivStages].blue,
                   green_out: side_q[dpb_pkg::DivStages].green,
                   red_out:   side_q[dpb_pkg::DivStages].red};
    end
  end

  assign point_valid_o = point_valid_q;
  assign point_o       = point_q;

endmodule

// File: sv/dpb_divider.sv
module dpb_divider (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [dpb_pkg::ProdW-1:0]              prod_i,
  input  logic                                   neg_i,
  input  logic [15:0]                            focal_i,
  output logic signed [dpb_pkg::CoordW-1:0]      coord_o
);

  logic [15:0] divisor;

  // stage 0 is the overflow check, stages 1..DivStages each retire one quotient bit
  logic [dpb_pkg::RemW-1:0]  rem_q  [dpb_pkg::DivStages+1];
  logic [dpb_pkg::QuotW-1:0] work_q [dpb_pkg::DivStages+1];
  logic                      sat_q  [dpb_pkg::DivStages+1];
  logic                      neg_q  [dpb_pkg::DivStages+1];

  logic [dpb_pkg::ProdW-dpb_pkg::QuotW-1:0] prod_hi;
  logic [dpb_pkg::QuotW:0]                  quot_ext;

  assign divisor = (focal_i == 16'd0) ? 16'd1 : focal_i;
  assign prod_hi = prod_i[dpb_pkg::ProdW-1:dpb_pkg::QuotW];

  // quotient reaches 2^23 exactly when the top bits alone reach the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= dpb_pkg::RemW'(prod_hi);
      work_q[0] <= prod_i[dpb_pkg::QuotW-1:0];
      sat_q[0]  <= 16'(prod_hi) >= divisor;
      neg_q[0]  <= neg_i;
    end
  end

  for (genvar k = 1; k <= dpb_pkg::DivStages; k++) begin : g_step
    logic [dpb_pkg::RemW:0] trial;
    logic                   fits;

    assign trial = {rem_q[k-1], work_q[k-1][dpb_pkg::QuotW-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? dpb_pkg::RemW'(trial - {1'b0, divisor})
                          : trial[dpb_pkg::RemW-1:0];
        work_q[k] <= {work_q[k-1][dpb_pkg::QuotW-2:0], fits};
        sat_q[k]  <= sat_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  assign quot_ext = {1'b0, work_q[dpb_pkg::DivStages]};

  always_comb begin
    if (sat_q[dpb_pkg::DivStages]) begin
      coord_o = neg_q[dpb_pkg::DivStages] ? dpb_pkg::CoordMin : dpb_pkg::CoordMax;
    end else if (neg_q[dpb_pkg::DivStages]) begin
      coord_o = -$signed(quot_ext);
    end else begin
      coord_o = $signed(quot_ext);
    end
  end

endmodule

// File: sv/dpb_checker.sv
`include "depth_pixel_backprojection_macros.svh"

module dpb_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            pixel_stall_o,
  input logic            point_valid_o,
  input dpb_pkg::point_t point_o,
  input logic            point_stall_i
);

  // a held point stays and keeps its payload
  `DPB_ASSERT_NEXT(a_point_hold, point_valid_o && point_stall_i, point_valid_o && $stable(point_o), "point changed while stalled")

  // back-pressure on pixels only comes from a blocked point
  `DPB_ASSERT_NOW(a_stall_cause, pixel_stall_o, point_valid_o && point_stall_i, "pixel stall without a blocked point")

  // a free output side never stalls the input
  `DPB_ASSERT_NOW(a_no_stall_free, !point_stall_i, !pixel_stall_o, "pixel stall while output free")

  // zero depth projects onto the origin
  `DPB_ASSERT_NOW(a_zero_depth, point_valid_o && (point_o.point_z == 16'd0), (point_o.point_x == '0) && (point_o.point_y == '0), "nonzero x or y at zero depth")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// File: verif/tb_depth_pixel_backprojection.sv
module tb_depth_pixel_backprojection;

  // request sources for the driver: a pixel, a register write, or a pause
  // that holds the pixel channel until every predicted point has come back
  typedef enum logic [1:0] {
    JOB_PIXEL,
    JOB_WRITE,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e          kind;
    dpb_pkg::pixel_t    pix;
    dpb_pkg::cfg_idx_e  idx;
    logic [15:0]        data;
  } job_t;

  // camera intrinsics and pixel filter as the predictor sees them
  typedef struct {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] dmin;
    logic [15:0] dmax;
    logic [3:0]  stride;
  } cam_cfg_t;

  localparam int SettleCycles  = 40;   // longer than the pipeline
  localparam int IdlePct       = 25;
  localparam int WatchdogLimit = 2000;
  localparam int MaxPrinted    = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  dpb_pkg::cfg_idx_e cfg_idx = dpb_pkg::CFG_FOCAL_X;
  logic [15:0] cfg_wdata = '0;
  logic     pixel_valid = 1'b0;
  dpb_pkg::pixel_t pixel = '0;
  logic     pixel_stall;
  logic     point_valid;
  dpb_pkg::point_t point;
  logic     point_stall = 1'b0;

  job_t     jobs[$];
  dpb_pkg::point_t points_due[$];
  cam_cfg_t gen_cfg;     // settings as the stimulus builder sees them
  cam_cfg_t live_cfg;    // settings the block holds right now
  int       settle_left = 0;
  int       pixels_accepted = 0;
  int       predicted_count = 0;
  int       points_checked = 0;
  int       writes_done = 0;
  int       settings_used = 0;
  int       error_count = 0;
  int       idle_cycles = 0;
  logic     calm = 1'b0;  // stretch with no idling on either side

  depth_pixel_backprojection DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pixel_valid_i(pixel_valid),
    .pixel_i      (pixel),
    .pixel_stall_o(pixel_stall),
    .point_valid_o(point_valid),
    .point_o      (point),
    .point_stall_i(point_stall)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic cam_cfg_t default_cfg();
    cam_cfg_t c;
    c.fx     = dpb_pkg::FocalXRst;
    c.fy     = dpb_pkg::FocalYRst;
    c.cx     = dpb_pkg::CenterXRst;
    c.cy     = dpb_pkg::CenterYRst;
    c.dmin   = dpb_pkg::MinDepthRst;
    c.dmax   = dpb_pkg::MaxDepthRst;
    c.stride = dpb_pkg::StrideRst;
    return c;
  endfunction

  function automatic cam_cfg_t apply_write(cam_cfg_t c, dpb_pkg::cfg_idx_e idx,
                                           logic [15:0] d);
    case (idx)
      dpb_pkg::CFG_FOCAL_X:      c.fx = d;
      dpb_pkg::CFG_FOCAL_Y:      c.fy = d;
      dpb_pkg::CFG_CENTER_X:     c.cx = d;
      dpb_pkg::CFG_CENTER_Y:     c.cy = d;
      dpb_pkg::CFG_MIN_DEPTH:    c.dmin = d;
      dpb_pkg::CFG_MAX_DEPTH:    c.dmax = d;
      dpb_pkg::CFG_PIXEL_STRIDE: c.stride = d[3:0];
      default: ;
    endcase
    return c;
  endfunction

  // stride zero behaves as one; depth window is inclusive at both ends
  function automatic bit pixel_kept(cam_cfg_t c, dpb_pkg::pixel_t p);
    logic [3:0] step;
    step = (c.stride == 4'd0) ? 4'd1 : c.stride;
    return (p.pixel_row % step == 0) && (p.pixel_col % step == 0) &&
           (p.depth_value >= c.dmin) && (p.depth_value <= c.dmax);
  endfunction

  // (index*16 - centre) * z / focal, truncated towards zero, clamped to 24 bits
  function automatic logic signed [23:0] axis_coord(logic [11:0] idx, logic [15:0] ctr,
                                                    logic [15:0] z, logic [15:0] focal);
    longint unsigned pos, mag, div, q;
    bit neg;
    pos = 64'({idx, 4'b0000});
    neg = pos < 64'(ctr);
    mag = neg ? 64'(ctr) - pos : pos - 64'(ctr);
    div = (focal == 16'd0) ? 64'd1 : 64'(focal);   // zero focal acts as one
    q   = (mag * 64'(z)) / div;
    if (neg) begin
      if (q > 64'd8388608) return dpb_pkg::CoordMin;
      return 24'(-q);
    end
    if (q > 64'd8388607) return dpb_pkg::CoordMax;
    return 24'(q);
  endfunction

  function automatic dpb_pkg::point_t project_pixel(cam_cfg_t c, dpb_pkg::pixel_t p);
    dpb_pkg::point_t pt;
    pt.point_x   = axis_coord(p.pixel_col, c.cx, p.depth_value, c.fx);
    pt.point_y   = axis_coord(p.pixel_row, c.cy, p.depth_value, c.fy);
    pt.point_z   = p.depth_value;
    pt.blue_out  = p.blue_in;
    pt.green_out = p.green_in;
    pt.red_out   = p.red_in;
    return pt;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("%s", msg);
  endtask

  task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want)
      flag_error($sformatf("point %0d %s: got %h, expected %h",
                           points_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic push_pixel(int row, int col, int depth, int b, int g, int r);
    job_t j;
    j.kind = JOB_PIXEL;
    j.pix.pixel_row   = 12'(row);
    j.pix.pixel_col   = 12'(col);
    j.pix.depth_value = 16'(depth);
    j.pix.blue_in     = 8'(b);
    j.pix.green_in    = 8'(g);
    j.pix.red_in      = 8'(r);
    j.idx  = dpb_pkg::CFG_FOCAL_X;
    j.data = '0;
    jobs.insert(jobs.size(), j);
  endtask

  task automatic push_write(dpb_pkg::cfg_idx_e idx, logic [15:0] d);
    job_t j;
    j.kind = JOB_WRITE;
    j.pix  = '0;
    j.idx  = idx;
    j.data = d;
    jobs.insert(jobs.size(), j);
    gen_cfg = apply_write(gen_cfg, idx, d);
  endtask

  // drain first, then rewrite every register; stride sometimes carries junk above bit 3
  task automatic push_setting(cam_cfg_t c);
    job_t j;
    j.kind = JOB_DRAIN;
    j.pix  = '0;
    j.idx  = dpb_pkg::CFG_FOCAL_X;
    j.data = '0;
    jobs.insert(jobs.size(), j);
    push_write(dpb_pkg::CFG_FOCAL_X, c.fx);
    push_write(dpb_pkg::CFG_FOCAL_Y, c.fy);
    push_write(dpb_pkg::CFG_CENTER_X, c.cx);
    push_write(dpb_pkg::CFG_CENTER_Y, c.cy);
    push_write(dpb_pkg::CFG_MIN_DEPTH, c.dmin);
    push_write(dpb_pkg::CFG_MAX_DEPTH, c.dmax);
    push_write(dpb_pkg::CFG_PIXEL_STRIDE,
               {($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'd0, c.stride});
    settings_used++;
  endtask

  function automatic cam_cfg_t random_setting();
    cam_cfg_t c;
    c.fx     = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 1599))
                                            : 16'($urandom_range(1600, 65535));
    c.fy     = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 1599))
                                            : 16'($urandom_range(1600, 65535));
    c.cx     = 16'($urandom_range(0, 65535));
    c.cy     = 16'($urandom_range(0, 65535));
    c.dmin   = 16'($urandom_range(0, 40000));
    c.dmax   = 16'($urandom_range(c.dmin, 65535));
    c.stride = 4'($urandom_range(1, 8));
    return c;
  endfunction

  // mostly pixels on the stride grid inside the depth window, the rest noise;
  // counts kept pixels, or every pixel when the window is inverted
  task automatic push_random(int want);
    int kept, step, depth;
    dpb_pkg::pixel_t p;
    job_t j;
    kept = 0;
    while (kept < want) begin
      step = (gen_cfg.stride == 4'd0) ? 1 : int'(gen_cfg.stride);
      p.pixel_row   = 12'($urandom);
      p.pixel_col   = 12'($urandom);
      p.depth_value = 16'($urandom);
      p.blue_in     = 8'($urandom);
      p.green_in    = 8'($urandom);
      p.red_in      = 8'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        p.pixel_row = 12'(step * $urandom_range(0, 4095 / step));
        p.pixel_col = 12'(step * $urandom_range(0, 4095 / step));
        if (gen_cfg.dmin <= gen_cfg.dmax) begin
          case ($urandom_range(0, 9))
            0:       depth = int'(gen_cfg.dmin);
            1:       depth = int'(gen_cfg.dmax);
            default: depth = int'($urandom_range(gen_cfg.dmin, gen_cfg.dmax));
          endcase
          p.depth_value = 16'(depth);
        end
      end
      if (pixel_kept(gen_cfg, p) || gen_cfg.dmin > gen_cfg.dmax) kept++;
      j.kind = JOB_PIXEL;
      j.pix  = p;
      j.idx  = dpb_pkg::CFG_FOCAL_X;
      j.data = '0;
      jobs.insert(jobs.size(), j);
    end
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver and register writer
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin : pixel_driver
    job_t              head;
    logic              nxt_valid, nxt_we;
    dpb_pkg::pixel_t   nxt_pix;
    dpb_pkg::cfg_idx_e nxt_idx;
    logic [15:0]       nxt_data;
    if (!rst_n) begin
      pixel_valid <= 1'b0;
      cfg_we      <= 1'b0;
    end else begin
      // predict on acceptance, with the settings the block holds now
      if (pixel_valid && !pixel_stall) begin
        pixels_accepted++;
        if (pixel_kept(live_cfg, pixel)) begin
          points_due.insert(points_due.size(), project_pixel(live_cfg, pixel));
          predicted_count++;
        end
      end
      nxt_valid = pixel_valid && pixel_stall;  // a stalled request holds
      nxt_pix   = pixel;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_idx;
      nxt_data  = cfg_wdata;
      if (!nxt_valid) begin
        if (settle_left != 0) begin
          settle_left--;
        end else if (jobs.size() != 0) begin
          case (jobs[0].kind)
            JOB_DRAIN: begin
              // points_checked is updated by nonblocking assignment, so this
              // sees last cycle's count whatever the block order
              if (points_checked == predicted_count) begin
                settle_left = SettleCycles;
                head = jobs.pop_front();
              end
            end
            JOB_WRITE: begin
              head      = jobs.pop_front();
              nxt_we    = 1'b1;
              nxt_idx   = head.idx;
              nxt_data  = head.data;
              live_cfg  = apply_write(live_cfg, head.idx, head.data);
              writes_done++;
            end
            default: begin
              if (calm || $urandom_range(0, 99) >= IdlePct) begin
                head      = jobs.pop_front();
                nxt_valid = 1'b1;
                nxt_pix   = head.pix;
              end
            end
          endcase
        end
      end
      pixel_valid <= nxt_valid;
      pixel       <= nxt_pix;
      cfg_we      <= nxt_we;
      cfg_idx     <= nxt_idx;
      cfg_wdata   <= nxt_data;
      calm        <= (pixels_accepted >= 120) && (pixels_accepted < 240);
    end
  end

  // ---------------------------------------------------------------------------
  // point monitor and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin : point_monitor
    dpb_pkg::point_t want;
    if (!rst_n) begin
      point_stall <= 1'b0;
    end else begin
      if (point_valid && !point_stall) begin
        if (points_due.size() == 0) begin
          flag_error($sformatf("unexpected point x=%h y=%h z=%h",
                               point.point_x, point.point_y, point.point_z));
        end else begin
          want = points_due.pop_front();
          check_field("x", point.point_x, want.point_x);
          check_field("y", point.point_y, want.point_y);
          check_field("z", 24'(point.point_z), 24'(want.point_z));
          check_field("blue", 24'(point.blue_out), 24'(want.blue_out));
          check_field("green", 24'(point.green_out), 24'(want.green_out));
          check_field("red", 24'(point.red_out), 24'(want.red_out));
          points_checked <= points_checked + 1;
        end
      end
      point_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (pixel_valid && !pixel_stall) || (point_valid && !point_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("no progress for %0d cycles, %0d points outstanding",
               WatchdogLimit, points_due.size());
      $display("FAIL depth_pixel_backprojection");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    cam_cfg_t c;
    live_cfg = default_cfg();
    gen_cfg  = default_cfg();

    // reset settings: depth window edges, stride rejects, far corner, colour extremes
    push_pixel(0, 0, 100, 8'h00, 8'h00, 8'h00);
    push_pixel(0, 0, 50000, 8'hff, 8'hff, 8'hff);
    push_pixel(0, 0, 99, 8'h12, 8'h34, 8'h56);
    push_pixel(0, 0, 50001, 8'h12, 8'h34, 8'h56);
    push_pixel(1, 0, 1000, 8'h5a, 8'ha5, 8'h3c);
    push_pixel(0, 4094, 1000, 8'h5a, 8'ha5, 8'h3c);
    push_pixel(4095, 4095, 50000, 8'hff, 8'h00, 8'hff);
    push_pixel(4095, 0, 65535, 8'h80, 8'h01, 8'h7f);

    // extremes one way, stride one
    c = '{fx: 16'd1600, fy: 16'd65535, cx: 16'd0, cy: 16'd65535,
          dmin: 16'd0, dmax: 16'd65535, stride: 4'd1};
    push_setting(c);
    push_pixel(4095, 4095, 65535, 8'hff, 8'h00, 8'hff);
    push_pixel(0, 0, 0, 8'h00, 8'hff, 8'h00);
    push_random(40);

    // extremes the other way, stride eight, one-value depth window
    c = '{fx: 16'd65535, fy: 16'd1600, cx: 16'd65535, cy: 16'd0,
          dmin: 16'd65535, dmax: 16'd65535, stride: 4'd8};
    push_setting(c);
    push_pixel(4088, 4088, 65535, 8'h11, 8'h22, 8'h33);
    push_pixel(4095, 0, 65535, 8'h11, 8'h22, 8'h33);
    push_random(20);

    // unit focal: exact negative limit, positive clamp, zero offset; stride zero
    c = '{fx: 16'd1, fy: 16'd1, cx: 16'd256, cy: 16'd0,
          dmin: 16'd0, dmax: 16'd65535, stride: 4'd0};
    push_setting(c);
    push_pixel(16, 0, 32768, 8'h01, 8'h02, 8'h03);
    push_pixel(0, 16, 32768, 8'h04, 8'h05, 8'h06);
    push_pixel(0, 0, 32769, 8'h07, 8'h08, 8'h09);
    push_pixel(4095, 4095, 65535, 8'hfe, 8'hfd, 8'hfc);
    push_random(30);

    // zero focal lengths act as one, so large offsets saturate; stride fifteen
    c = '{fx: 16'd0, fy: 16'd0, cx: 16'd5120, cy: 16'd3840,
          dmin: 16'd1, dmax: 16'd65535, stride: 4'd15};
    push_setting(c);
    push_pixel(0, 0, 1, 8'haa, 8'hbb, 8'hcc);
    push_pixel(4095, 4095, 65535, 8'hdd, 8'hee, 8'hff);
    push_random(15);

    // inverted depth limits keep nothing
    c = '{fx: 16'd8000, fy: 16'd8000, cx: 16'd5120, cy: 16'd3840,
          dmin: 16'd40000, dmax: 16'd100, stride: 4'd2};
    push_setting(c);
    push_pixel(0, 0, 40000, 8'h01, 8'h01, 8'h01);
    push_pixel(0, 0, 100, 8'h01, 8'h01, 8'h01);
    push_pixel(0, 0, 5000, 8'h01, 8'h01, 8'h01);
    push_random(30);

    // random camera settings
    repeat (6) begin
      push_setting(random_setting());
      push_random(35);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // the last request may still be in flight when the queues first look empty
    do begin
      while (jobs.size() != 0 || pixel_valid || points_due.size() != 0)
        @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
    end while (jobs.size() != 0 || pixel_valid || points_due.size() != 0);

    $display("checked %0d points from %0d pixel requests over %0d camera settings",
             points_checked, pixels_accepted, settings_used + 1);
    $display("%0d register writes; zero focal, zero and wide stride, inverted window, clamping",
             writes_done);
    if (error_count == 0) begin
      $display("PASS depth_pixel_backprojection");
    end else begin
      $display("FAIL depth_pixel_backprojection");
    end
    $finish;
  end

endmodule
